### hdl/chat_keyword_class_detector_macros.svh
// Assertion macros used by the checker file.
`ifndef CHAT_KEYWORD_CLASS_DETECTOR_MACROS_SVH
`define CHAT_KEYWORD_CLASS_DETECTOR_MACROS_SVH

// Check a property outside reset.
`define KCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define KCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/kcd_pkg.sv
package kcd_pkg;

    localparam int KCD_MAX_KEYWORD_LEN = 14;  // default window span in bytes
    localparam int KCD_NUM_KEYWORDS    = 15;
    localparam int KCD_KW_TEXT_LEN     = 14;  // longest keyword in bytes
    localparam int KCD_KW_LEN_W        = $clog2(KCD_KW_TEXT_LEN + 1);

    typedef logic [KCD_KW_TEXT_LEN*8-1:0] t_kw_text;
    typedef logic [KCD_KW_LEN_W-1:0]      t_kw_len;

    // One bit per keyword class; thanks in the lowest bit.
    typedef struct packed {
        logic please;
        logic welcome;
        logic thanks;
    } t_class_flags;

    typedef enum logic [1:0] {
        CLS_THANKS  = 2'd0,
        CLS_WELCOME = 2'd1,
        CLS_PLEASE  = 2'd2
    } t_kw_class;

    // Lower-case keyword text, right-justified: byte 0 holds the final
    // character, so byte i lines up with the window byte i steps back.
    function automatic t_kw_text kw_text(input int k);
        t_kw_text t;
        unique case (k)
            0:       t = t_kw_text'("thank you");
            1:       t = t_kw_text'("thanks");
            2:       t = t_kw_text'("ty");
            3:       t = t_kw_text'("thanx");
            4:       t = t_kw_text'("thnx");
            5:       t = t_kw_text'("you're welcome");
            6:       t = t_kw_text'("youre welcome");
            7:       t = t_kw_text'("your welcome");
            8:       t = t_kw_text'("yw");
            9:       t = t_kw_text'("no problem");
            10:      t = t_kw_text'("no prob");
            11:      t = t_kw_text'("np");
            12:      t = t_kw_text'("please");
            13:      t = t_kw_text'("pls");
            default: t = t_kw_text'("plz");
        endcase
        return t;
    endfunction

    function automatic t_kw_len kw_len(input int k);
        t_kw_len n;
        unique case (k)
            0:       n = t_kw_len'(9);
            1:       n = t_kw_len'(6);
            2:       n = t_kw_len'(2);
            3:       n = t_kw_len'(5);
            4:       n = t_kw_len'(4);
            5:       n = t_kw_len'(14);
            6:       n = t_kw_len'(13);
            7:       n = t_kw_len'(12);
            8:       n = t_kw_len'(2);
            9:       n = t_kw_len'(10);
            10:      n = t_kw_len'(7);
            11:      n = t_kw_len'(2);
            12:      n = t_kw_len'(6);
            default: n = t_kw_len'(3);
        endcase
        return n;
    endfunction

    function automatic t_kw_class kw_class(input int k);
        t_kw_class c;
        if (k < 5) begin
            c = CLS_THANKS;
        end else if (k < 12) begin
            c = CLS_WELCOME;
        end else begin
            c = CLS_PLEASE;
        end
        return c;
    endfunction

    // Fold ASCII upper case to lower case; leave every other byte alone.
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

### hdl/kcd_matcher.sv
module kcd_matcher #(
    parameter int MAX_KEYWORD_LEN = kcd_pkg::KCD_MAX_KEYWORD_LEN
) (
    input  logic [MAX_KEYWORD_LEN-1:0][7:0] i_window,  // byte 0 newest
    output kcd_pkg::t_class_flags           o_hits
);
    import kcd_pkg::*;

    logic [KCD_NUM_KEYWORDS-1:0] w_kw_hit;

    // Each keyword is tested for ending at the newest byte, all in parallel.
    always_comb begin
        t_kw_text txt;
        t_kw_len  len;
        for (int k = 0; k < KCD_NUM_KEYWORDS; k++) begin
            txt         = kw_text(k);
            len         = kw_len(k);
            w_kw_hit[k] = 1'b1;
            for (int i = 0; i < KCD_KW_TEXT_LEN; i++) begin
                if (i < int'(len) && i_window[i] != txt[i*8 +: 8]) begin
                    w_kw_hit[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_hits = '0;
        for (int k = 0; k < KCD_NUM_KEYWORDS; k++) begin
            if (w_kw_hit[k]) begin
                unique case (kw_class(k))
                    CLS_THANKS:  o_hits.thanks  = 1'b1;
                    CLS_WELCOME: o_hits.welcome = 1'b1;
                    CLS_PLEASE:  o_hits.please  = 1'b1;
                    default:     o_hits         = o_hits;
                endcase
            end
        end
    end

endmodule

### hdl/chat_keyword_class_detector.sv
// Result path: the last byte of a message passes the input register, then the
// result register, whose content shows on m_axis; one result per message,
// none for the other bytes.
// Throughput: 1 byte per cycle; the matcher compares all keywords in parallel
// in the single stage between the input and result registers. A last byte
// waits in the input register only while an earlier result is still held.
// Reset: synchronous, active low; clears the window, the class flags and
// both valid flags.
module chat_keyword_class_detector #(
    parameter int MAX_KEYWORD_LEN = kcd_pkg::KCD_MAX_KEYWORD_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  logic       s_axis_tlast,   // end_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] thanks_found, [1] welcome_found,
                                       // [2] please_found, [7:3] zero
);
    import kcd_pkg::*;

    localparam int HistLen = MAX_KEYWORD_LEN - 1;

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Message state: folded history (newest at index 0) and sticky flags.
    logic [HistLen-1:0][7:0] r_hist;
    t_class_flags            r_flags;

    // Result register.
    logic         r_out_valid;
    t_class_flags r_out_flags;

    logic [MAX_KEYWORD_LEN-1:0][7:0] w_window;
    t_class_flags                    w_hits;
    t_class_flags                    n_flags;
    logic                            w_advance;

    assign w_window = {r_hist, fold_case(r_in_byte)};

    kcd_matcher #(
        .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
    ) u_matcher (
        .i_window(w_window),
        .o_hits  (w_hits)
    );

    assign n_flags = r_flags | w_hits;

    // A middle byte always moves on; a last byte needs room in the result
    // register, which frees up in the same cycle it is taken.
    assign w_advance = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);

    assign s_axis_tready = !r_in_valid || w_advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_flags};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hist      <= '0;
            r_flags     <= '0;
        end else begin
            // Load the next byte whenever the input stage empties.
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end

            // Load a new result, or drop the held one once the downstream
            // side takes it.
            if (w_advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_advance) begin
                if (r_in_last) begin
                    // Report the message and clear for the next one.
                    r_hist  <= '0;
                    r_flags <= '0;
                end else begin
                    r_hist  <= w_window[HistLen-1:0];
                    r_flags <= n_flags;
                end
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (w_advance && r_in_last) begin
            r_out_flags <= n_flags;
        end
    end

endmodule

### hdl/kcd_checker.sv
`include "chat_keyword_class_detector_macros.svh"

module kcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A pending result stays until taken.
    `KCD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `KCD_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

    // Unused result bits are zero on every valid result.
    `KCD_ASSERT(a_out_pad, m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b0, "result padding not zero")

    // Reset leaves no result pending.
    `KCD_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // The input stalls only behind a result that is still held.
    `KCD_ASSERT(a_in_stall, s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without a held result")

endmodule

bind chat_keyword_class_detector kcd_checker u_kcd_checker (.*);

### verif/kcd_class_checker.sv
`timescale 1ns / 1ps

// Watch both stream ports, predict the keyword classes of each message and
// compare every result transfer with the oldest prediction.
module kcd_class_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_byte
    input  logic       i_s_axis_tlast,   // end_of_message
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [0] thanks, [1] welcome, [2] please, [7:3] zero
    output int         o_fail_count,
    output int         o_pending
);
    import kcd_pkg::*;

    localparam int WINDOW_BYTES = KCD_MAX_KEYWORD_LEN;

    string keywords [KCD_NUM_KEYWORDS] = '{
        "thank you", "thanks", "ty", "thanx", "thnx",
        "you're welcome", "youre welcome", "your welcome", "yw",
        "no problem", "no prob", "np",
        "please", "pls", "plz"
    };
    t_kw_class keyword_cls [KCD_NUM_KEYWORDS] = '{
        CLS_THANKS, CLS_THANKS, CLS_THANKS, CLS_THANKS, CLS_THANKS,
        CLS_WELCOME, CLS_WELCOME, CLS_WELCOME, CLS_WELCOME,
        CLS_WELCOME, CLS_WELCOME, CLS_WELCOME,
        CLS_PLEASE, CLS_PLEASE, CLS_PLEASE
    };

    logic [7:0]   history [WINDOW_BYTES-1];  // folded bytes, newest first
    t_class_flags seen;                      // sticky classes of this message
    t_class_flags expected_classes [$];
    int           fails = 0;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    // Classes of every keyword that ends at the newest byte w[0].
    function automatic t_class_flags classes_ending_here(input logic [7:0] w [WINDOW_BYTES]);
        t_class_flags f;
        int           n;
        logic         hit;
        f = '0;
        for (int k = 0; k < KCD_NUM_KEYWORDS; k++) begin
            n   = keywords[k].len();
            hit = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (w[i] != 8'(keywords[k][n-1-i])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                case (keyword_cls[k])
                    CLS_THANKS:  f.thanks  = 1'b1;
                    CLS_WELCOME: f.welcome = 1'b1;
                    default:     f.please  = 1'b1;
                endcase
            end
        end
        return f;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        logic [7:0]   win [WINDOW_BYTES];
        t_class_flags want;
        if (!i_rst_n) begin
            foreach (history[i]) history[i] = 8'h00;
            seen = '0;
            expected_classes.delete();
        end else begin
            // Results first: a result leaving now was predicted earlier.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_classes.size() == 0) begin
                    $error("result 0x%02h arrived with no message pending", i_m_axis_tdata);
                    fails++;
                end else begin
                    want = expected_classes.pop_front();
                    check_field("thanks_found", 8'(want.thanks), 8'(i_m_axis_tdata[0]));
                    check_field("welcome_found", 8'(want.welcome), 8'(i_m_axis_tdata[1]));
                    check_field("please_found", 8'(want.please), 8'(i_m_axis_tdata[2]));
                    check_field("tdata padding", 8'h00, 8'(i_m_axis_tdata[7:3]));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                win[0] = to_lower(i_s_axis_tdata);
                for (int i = 1; i < WINDOW_BYTES; i++) begin
                    win[i] = history[i-1];
                end
                seen = t_class_flags'(seen | classes_ending_here(win));
                if (i_s_axis_tlast) begin
                    expected_classes.push_back(seen);
                    seen = '0;
                    foreach (history[i]) history[i] = 8'h00;
                end else begin
                    foreach (history[i]) history[i] = win[i];
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_classes.size();
    end

endmodule

### verif/tb_chat_keyword_class_detector.sv
`timescale 1ns / 1ps

module tb_chat_keyword_class_detector;

    localparam int RANDOM_BYTES = 1300;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either port

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_byte
    logic       s_axis_tlast = 1'b0;    // end_of_message
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [0] thanks, [1] welcome, [2] please, [7:3] zero

    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         burst_left = 0;
    int         sent = 0;
    logic [7:0] msg_bytes [$];
    logic [15:0] ready_cycle = '0;
    int         ready_mode = 0;

    // Keywords, near misses and fragments used to build messages.
    string vocab [] = '{
        "thank you", "thanks", "ty", "thanx", "thnx",
        "you're welcome", "youre welcome", "your welcome", "yw",
        "no problem", "no prob", "np", "please", "pls", "plz",
        "thank", "welcome", "you re welcome", "prob", "plea", "tyw", "p l s"
    };
    // Most letters of the keywords, space and apostrophe, plus the bytes just outside both letter ranges.
    string filler = "aehklnoprstuwxyz '@[\140{";

    chat_keyword_class_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    kcd_class_checker u_class_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #1 i_clk = ~i_clk;

    // Result-side backpressure: pick a stall mode whenever the low six bits of the cycle counter are zero
    // so that stretches of full speed alternate with light, heavy and periodic stalls.
    always @(negedge i_clk) begin
        if (ready_cycle[5:0] == 6'd0) begin
            ready_mode = $urandom_range(0, 3);
        end
        ready_cycle <= ready_cycle + 16'd1;
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ready_cycle[3];
        endcase
    end

    // Watchdog: end the run once neither port has moved a transfer for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one byte and hold it until the transfer; call at a falling edge.
    // Between bursts, drop tvalid for a random gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        sent++;
    endtask

    task automatic send_message();
        foreach (msg_bytes[i]) begin
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        msg_bytes.delete();
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(8'(s[i]));
        send_message();
    endtask

    // Hold the input idle until every predicted result has left the block.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Push a byte, raising lower-case letters to upper case at random.
    task automatic push_char(input logic [7:0] b);
        if (b >= 8'h61 && b <= 8'h7A && $urandom_range(0, 1) == 1) begin
            b = b - 8'h20;
        end
        msg_bytes.push_back(b);
    endtask

    // Push a word with random case and an occasional corrupted byte.
    task automatic push_word(input string s);
        for (int i = 0; i < s.len(); i++) begin
            if ($urandom_range(0, 23) == 0) begin
                push_char(8'($urandom));
            end else begin
                push_char(8'(s[i]));
            end
        end
    endtask

    // Mostly keyword-bearing text with random case and filler; some pure noise,
    // some long messages that push keywords through the whole window.
    task automatic build_random_message();
        int style;
        int parts;
        msg_bytes.delete();
        style = $urandom_range(0, 9);
        if (style < 2) begin
            repeat ($urandom_range(1, 20)) msg_bytes.push_back(8'($urandom));
        end else begin
            parts = $urandom_range(1, (style == 9) ? 8 : 3);
            repeat (parts) begin
                if ($urandom_range(0, 1) == 1) begin
                    push_word(vocab[$urandom_range(0, vocab.size() - 1)]);
                end else begin
                    repeat ($urandom_range(0, 4)) begin
                        push_char(8'(filler[$urandom_range(0, filler.len() - 1)]));
                    end
                end
            end
            if (msg_bytes.size() == 0) begin
                push_char(8'h79);
            end
        end
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero byte and all-ones byte as single-byte messages,
        // a split "t" / "y" that must not match across messages, the longest
        // keyword in mixed case, and short keywords in odd case.
        msg_bytes = '{8'h00};
        send_message();
        msg_bytes = '{8'hFF};
        send_message();
        send_text("t");
        send_text("y");
        send_text("You're Welcome");
        send_text("PlZ");
        send_text("NP");
        drain_results();

        // Random messages; pause once midway until the block has emptied.
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_random_message();
            send_message();
            if (!paused && sent >= RANDOM_BYTES / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
